// ----- src/rpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants of the rating pair table
// field widths, operation and status codes, cell token
// ----------------------------------------------------------------------------
`default_nettype none

package rpt_pkg;

  localparam int unsigned Entries  = 64;
  localparam int unsigned IdBits   = 16;
  localparam int unsigned RateBits = 7;
  localparam int unsigned CntBits  = $clog2(Entries + 1);
  localparam int unsigned SumBits  = $clog2(Entries * 100 + 1);
  localparam int unsigned MaxRating = 100;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpRating = 2'd2;
  localparam logic [1:0] OpAvg    = 2'd3;

  localparam logic [2:0] StAdded   = 3'd0;
  localparam logic [2:0] StUpdated = 3'd1;
  localparam logic [2:0] StRemoved = 3'd2;
  localparam logic [2:0] StAbsent  = 3'd3;
  localparam logic [2:0] StFound   = 3'd4;
  localparam logic [2:0] StAvg     = 3'd5;
  localparam logic [2:0] StFull    = 3'd6;

  // token handed from cell to cell, one hop a cycle
  typedef struct packed {
    logic                live;
    logic [1:0]          op;
    logic [IdBits-1:0]   user;
    logic [IdBits-1:0]   item;
    logic [RateBits-1:0] rating;
    logic                hit;
    logic [RateBits-1:0] hit_rating;
    logic [SumBits-1:0]  sum;
    logic [CntBits-1:0]  cnt;
  } token_t;

  // second pass command for insert of a new pair
  typedef struct packed {
    logic                live;
    logic                done;
    logic [IdBits-1:0]   user;
    logic [IdBits-1:0]   item;
    logic [RateBits-1:0] rating;
  } fill_t;

endpackage

`default_nettype wire

// ----- src/rpt_cell.sv -----
// ----------------------------------------------------------------------------
// rpt_cell: one table slot
// holds one entry, matches the passing token and forwards it
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rpt_pkg::token_t tok_i,
  output rpt_pkg::token_t      tok_o,
  input  wire rpt_pkg::fill_t  fill_i,
  output rpt_pkg::fill_t       fill_o
);

  logic                         valid_q;
  logic [rpt_pkg::IdBits-1:0]   user_q, item_q;
  logic [rpt_pkg::RateBits-1:0] rating_q;
  rpt_pkg::token_t              tok_d, tok_q;
  rpt_pkg::fill_t               fill_d, fill_q;
  logic                         pair_m, item_m, take;

  assign item_m = valid_q && item_q == tok_i.item;
  assign pair_m = item_m && user_q == tok_i.user && !tok_i.hit;
  assign take   = fill_i.live && !fill_i.done && !valid_q;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.live && tok_i.op != rpt_pkg::OpAvg && pair_m) begin
      tok_d.hit        = 1'b1;
      tok_d.hit_rating = rating_q;
    end
    if (tok_i.live && tok_i.op == rpt_pkg::OpAvg && item_m) begin
      tok_d.sum = tok_i.sum + rpt_pkg::SumBits'(rating_q);
      tok_d.cnt = tok_i.cnt + 1'b1;
    end
    fill_d = fill_i;
    if (take) fill_d.done = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      tok_q.live  <= 1'b0;
      fill_q.live <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      fill_q <= fill_d;
      if (tok_i.live && pair_m) begin
        if (tok_i.op == rpt_pkg::OpInsert) rating_q <= tok_i.rating;
        if (tok_i.op == rpt_pkg::OpRemove) valid_q  <= 1'b0;
      end
      if (take) begin
        valid_q  <= 1'b1;
        user_q   <= fill_i.user;
        item_q   <= fill_i.item;
        rating_q <= fill_i.rating;
      end
    end
  end

  assign tok_o  = tok_q;
  assign fill_o = fill_q;

endmodule

`default_nettype wire

// ----- src/rpt_div.sv -----
// ----------------------------------------------------------------------------
// rpt_div: restoring divider for the rounded average
// computes (2*sum+cnt)/(2*cnt) one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rpt_pkg::SumBits-1:0] sum_i,
  input  wire logic [rpt_pkg::CntBits-1:0] cnt_i,
  output logic                             done_o,
  output logic [rpt_pkg::RateBits-1:0]     quo_o
);

  localparam int unsigned NB = rpt_pkg::SumBits + 2;
  localparam int unsigned SB = $clog2(NB + 1);

  logic [NB-1:0] num_q, num_d, rem_q, rem_d, den_q;
  logic [NB-1:0] rsh;
  logic [SB-1:0] step_q;
  logic          busy_q;

  always_comb begin
    rsh   = {rem_q[NB-2:0], num_q[NB-1]};
    num_d = {num_q[NB-2:0], 1'b0};
    rem_d = rsh;
    if (rsh >= den_q) begin
      rem_d    = rsh - den_q;
      num_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        num_q  <= NB'({sum_i, 1'b0}) + NB'(cnt_i);
        rem_q  <= '0;
        den_q  <= NB'({cnt_i, 1'b0});
        step_q <= SB'(NB);
      end else if (busy_q) begin
        num_q  <= num_d;
        rem_q  <= rem_d;
        step_q <= step_q - 1'b1;
        if (step_q == SB'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // quotient never exceeds the maximum rating
  assign quo_o = (num_q > NB'(rpt_pkg::MaxRating)) ? rpt_pkg::RateBits'(rpt_pkg::MaxRating)
                                                   : num_q[rpt_pkg::RateBits-1:0];

endmodule

`default_nettype wire

// ----- src/rating_pair_table_unit.sv -----
// ----------------------------------------------------------------------------
// rating_pair_table_unit: (user, item) rating table with item average
// a chain of slot cells scanned by a token, plus a serial divider
// ----------------------------------------------------------------------------
// channel  dir  bits  content
// s_axis   in   48    op, user_id, item_id, rating_tenths
// m_axis   out  24    status, value_tenths, match_count
//
// one item at a time: the token walks the 64 cells, one cell a cycle
// insert of a new pair takes a second walk through the 64 cells to fill a free slot
// average adds a serial restoring divide once the walk is through
// reset clears all valid bits at once; no clearing pass
// the result sits in an output register until taken; a stall holds it
// ----------------------------------------------------------------------------
`default_nettype none

module rating_pair_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[1:0], user_id[17:2], item_id[33:18], rating_tenths[40:34], zero fill
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], value_tenths[9:3], match_count[16:10], zero fill
  output logic [23:0]      m_axis_tdata
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SFill = 2'd2;
  localparam logic [1:0] SDiv  = 2'd3;

  localparam int unsigned N = rpt_pkg::Entries;

  rpt_pkg::token_t tok [N+1];
  rpt_pkg::fill_t  fil [N+1];

  logic [1:0] state_q;
  logic       busy_q, ovalid_q;
  logic [2:0] st_q;
  logic [rpt_pkg::RateBits-1:0] val_q;
  logic [rpt_pkg::CntBits-1:0]  cnt_q;
  logic [rpt_pkg::RateBits-1:0] rin;
  logic                   tok_in, fill_in;
  rpt_pkg::token_t        head;
  rpt_pkg::token_t        tail;
  logic div_start, div_done;
  logic [rpt_pkg::RateBits-1:0] quo;

  // clip the rating to the top of its range
  assign rin = (s_axis_tdata[40:34] > rpt_pkg::RateBits'(rpt_pkg::MaxRating))
             ? rpt_pkg::RateBits'(rpt_pkg::MaxRating) : s_axis_tdata[40:34];

  assign s_axis_tready = !busy_q && !ovalid_q;
  assign tok_in = s_axis_tvalid && s_axis_tready;

  always_comb begin
    head            = '0;
    head.live       = tok_in;
    head.op         = s_axis_tdata[1:0];
    head.user       = s_axis_tdata[17:2];
    head.item       = s_axis_tdata[33:18];
    head.rating     = rin;
  end
  assign tok[0] = head;
  assign tail   = tok[N];

  // a second walk places a new pair in the lowest free slot
  assign fill_in = state_q == SScan && tail.live && tail.op == rpt_pkg::OpInsert && !tail.hit;
  assign fil[0]  = '{live: fill_in, done: 1'b0, user: tail.user, item: tail.item,
                     rating: tail.rating};

  for (genvar g = 0; g < N; g++) begin : g_cell
    rpt_cell u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni),
      .tok_i (tok[g]), .tok_o(tok[g+1]),
      .fill_i(fil[g]), .fill_o(fil[g+1])
    );
  end

  assign div_start = state_q == SScan && tail.live && tail.op == rpt_pkg::OpAvg
                     && tail.cnt != '0;

  rpt_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .sum_i(tail.sum), .cnt_i(tail.cnt), .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        SIdle: if (tok_in) begin
          state_q <= SScan;
          busy_q  <= 1'b1;
        end
        SScan: if (tail.live) begin
          val_q <= '0;
          cnt_q <= '0;
          case (tail.op)
            rpt_pkg::OpInsert: begin
              if (tail.hit) begin
                st_q <= rpt_pkg::StUpdated; ovalid_q <= 1'b1;
                state_q <= SIdle; busy_q <= 1'b0;
              end else state_q <= SFill;
            end
            rpt_pkg::OpRemove: begin
              st_q <= tail.hit ? rpt_pkg::StRemoved : rpt_pkg::StAbsent;
              ovalid_q <= 1'b1; state_q <= SIdle; busy_q <= 1'b0;
            end
            rpt_pkg::OpRating: begin
              st_q  <= tail.hit ? rpt_pkg::StFound : rpt_pkg::StAbsent;
              val_q <= tail.hit ? tail.hit_rating : '0;
              ovalid_q <= 1'b1; state_q <= SIdle; busy_q <= 1'b0;
            end
            default: begin
              st_q  <= rpt_pkg::StAvg;
              cnt_q <= tail.cnt;
              if (tail.cnt == '0) begin
                ovalid_q <= 1'b1; state_q <= SIdle; busy_q <= 1'b0;
              end else state_q <= SDiv;
            end
          endcase
        end
        SFill: if (fil[N].live) begin
          st_q     <= fil[N].done ? rpt_pkg::StAdded : rpt_pkg::StFull;
          ovalid_q <= 1'b1; state_q <= SIdle; busy_q <= 1'b0;
        end
        SDiv: if (div_done) begin
          val_q    <= quo;
          ovalid_q <= 1'b1; state_q <= SIdle; busy_q <= 1'b0;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, cnt_q, val_q, st_q};

`ifndef SYNTHESIS
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready) else $error("input taken while busy");
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !busy_q) else $error("idle but busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
